@@ src/tgs_pkg.sv @@
// Shared types and constants for the tile grid store.
package tgs_pkg;
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STACK_DEPTH = 16384;
  localparam int CW          = 6;                 // coordinate bits
  localparam int ADDR_W      = 2 * CW;
  localparam int TILES       = MAX_WIDTH * MAX_HEIGHT;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int SC_W        = SP_W + 1;
  localparam int TILE_W      = 17;
  localparam int ENTRY_W     = 14;

  typedef enum logic [2:0] {
    M_WRITE = 3'd0, M_READ = 3'd1, M_PAINT = 3'd2,
    M_FILL  = 3'd3, M_SOLID = 3'd4, M_CLEAR = 3'd5
  } mode_t;

  typedef enum logic [0:0] {R_WIDTH = 1'b0, R_HEIGHT = 1'b1} reg_idx_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WR, S_RD, S_RD2, S_PSET, S_PAINT, S_SRD, S_SWR,
    S_FSEED, S_FOLD, S_FPOP, S_FSRD, S_FCHK, S_FPUSH, S_DONE
  } state_t;

  function automatic logic inside_grid(logic signed [7:0] x, logic signed [7:0] y,
                                       logic [6:0] w, logic [6:0] h);
    return !x[7] && !y[7] && (x[6:0] < w) && (y[6:0] < h);
  endfunction
endpackage

@@ src/tgs_if.sv @@
// Item, result and configuration channels of the tile grid store.
interface tgs_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [7:0] x;
  logic signed [7:0] y;
  logic [5:0]        radius;
  logic [15:0]       tile_id;
  logic              solid;
  modport source (output valid, mode, x, y, radius, tile_id, solid, input ready);
  modport sink (input valid, mode, x, y, radius, tile_id, solid, output ready);
endinterface

interface tgs_out_if;
  logic        valid;
  logic        ready;
  logic        in_bounds;
  logic [15:0] read_id;
  logic        read_solid;
  logic        overflow;
  modport source (output valid, in_bounds, read_id, read_solid, overflow, input ready);
  modport sink (input valid, in_bounds, read_id, read_solid, overflow, output ready);
endinterface

interface tgs_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/tgs_ram.sv @@
// Single-port RAM with registered read.
module tgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ src/tile_grid_store_with_flood_fill.sv @@
// Tile grid store top level: sequencer over the tile RAM and the fill stack.
// A 64x64 grid of 17-bit tiles (16-bit id, solid flag) in one single-port RAM,
// cell (x,y) at y*64+x. After reset the block clears the whole store and
// takes no item meanwhile. One item at a time, one result per item; the
// result register lets the next item in while a result waits. Item cost is
// set by the single tile RAM port: clear redoes the reset clear, paint writes
// each clipped cell, solid-by-id reads each in-use cell and rewrites it on an
// id match, flood fill paints each popped cell holding the old id and pushes
// its in-grid neighbors; an out-of-bounds seed or a same-id fill ends early.
module tile_grid_store_with_flood_fill (
  input logic        clk,
  input logic        rst,
  tgs_in_if.sink     in_ch,
  tgs_out_if.source  out_ch,
  tgs_cfg_if.sink    cfg
);
  import tgs_pkg::*;

  state_t state, state_next;

  logic [6:0] map_width, map_height, wu, hu;
  logic signed [7:0] x_r, y_r;
  logic [5:0] r_r;
  logic [15:0] id_r;
  logic sol_r;

  logic [CW-1:0] px, py, lo_x, hi_x, hi_y;
  logic [CW-1:0] px_next, py_next, lo_x_next, hi_x_next, hi_y_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic clr_cmd, clr_cmd_next;
  logic [15:0] old_id, old_id_next;
  logic [CW-1:0] cx, cy, cx_next, cy_next;
  logic [1:0] k, k_next;
  logic [SC_W-1:0] scount, scount_next;
  logic res_ib, res_ib_next, res_ovf, res_ovf_next, res_sol, res_sol_next;
  logic [15:0] res_id, res_id_next;

  logic [ADDR_W-1:0] t_addr;
  logic t_we;
  logic [TILE_W-1:0] t_wd, t_rd;
  logic [SP_W-1:0] s_addr;
  logic s_we;
  logic [ENTRY_W-1:0] s_wd, s_rd;

  logic signed [9:0] xs, ys, rs, lxs, hxs, lys, hys, wm1, hm1;
  logic signed [7:0] nx, ny;
  logic n_in, load_out;

  assign wu = (map_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : map_width;
  assign hu = (map_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : map_height;
  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == S_IDLE);

  tgs_ram #(.WIDTH(TILE_W), .DEPTH(TILES)) u_tiles (
    .clk(clk), .addr(t_addr), .we(t_we), .wdata(t_wd), .rdata(t_rd));
  tgs_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .addr(s_addr), .we(s_we), .wdata(s_wd), .rdata(s_rd));

  // clipped square bounds
  always_comb begin
    xs  = 10'(x_r);
    ys  = 10'(y_r);
    rs  = {4'b0, r_r};
    wm1 = $signed({3'b0, wu}) - 10'sd1;
    hm1 = $signed({3'b0, hu}) - 10'sd1;
    lxs = (xs - rs < 0) ? 10'sd0 : xs - rs;
    lys = (ys - rs < 0) ? 10'sd0 : ys - rs;
    hxs = (xs + rs > wm1) ? wm1 : xs + rs;
    hys = (ys + rs > hm1) ? hm1 : ys + rs;
  end

  // neighbor order: x+1, x-1, y+1, y-1
  always_comb begin
    nx = {2'b0, cx};
    ny = {2'b0, cy};
    case (k)
      2'd0: nx = {2'b0, cx} + 8'sd1;
      2'd1: nx = {2'b0, cx} - 8'sd1;
      2'd2: ny = {2'b0, cy} + 8'sd1;
      default: ny = {2'b0, cy} - 8'sd1;
    endcase
    n_in = inside_grid(nx, ny, wu, hu);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      map_width <= '0;
      map_height <= '0;
      clr_addr <= '0;
      clr_cmd <= 1'b0;
      scount <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      clr_addr <= clr_addr_next;
      clr_cmd <= clr_cmd_next;
      scount <= scount_next;
      if (cfg.valid) begin
        unique case (reg_idx_t'(cfg.index))
          R_WIDTH:  map_width <= cfg.data;
          R_HEIGHT: map_height <= cfg.data;
          default: ;
        endcase
      end
      if (load_out) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      x_r <= in_ch.x;
      y_r <= in_ch.y;
      r_r <= in_ch.radius;
      id_r <= in_ch.tile_id;
      sol_r <= in_ch.solid;
    end
    px <= px_next;
    py <= py_next;
    lo_x <= lo_x_next;
    hi_x <= hi_x_next;
    hi_y <= hi_y_next;
    old_id <= old_id_next;
    cx <= cx_next;
    cy <= cy_next;
    k <= k_next;
    res_ib <= res_ib_next;
    res_id <= res_id_next;
    res_sol <= res_sol_next;
    res_ovf <= res_ovf_next;
    if (load_out) begin
      out_ch.in_bounds <= res_ib;
      out_ch.read_id <= res_id;
      out_ch.read_solid <= res_sol;
      out_ch.overflow <= res_ovf;
    end
  end

  always_comb begin
    state_next = state;
    px_next = px;
    py_next = py;
    lo_x_next = lo_x;
    hi_x_next = hi_x;
    hi_y_next = hi_y;
    clr_addr_next = clr_addr;
    clr_cmd_next = clr_cmd;
    old_id_next = old_id;
    cx_next = cx;
    cy_next = cy;
    k_next = k;
    scount_next = scount;
    res_ib_next = res_ib;
    res_id_next = res_id;
    res_sol_next = res_sol;
    res_ovf_next = res_ovf;
    t_addr = {y_r[CW-1:0], x_r[CW-1:0]};
    t_we = 1'b0;
    t_wd = {sol_r, id_r};
    s_addr = scount[SP_W-1:0];
    s_we = 1'b0;
    s_wd = {1'b0, ny[CW-1:0], 1'b0, nx[CW-1:0]};
    load_out = 1'b0;

    unique case (state)
      S_INIT: begin
        t_addr = clr_addr;
        t_we = 1'b1;
        t_wd = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (&clr_addr) begin
          state_next = clr_cmd ? S_DONE : S_IDLE;
          clr_cmd_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          res_ib_next = 1'b0;
          res_id_next = '0;
          res_sol_next = 1'b0;
          res_ovf_next = 1'b0;
          unique case (in_ch.mode)
            M_WRITE: state_next = S_WR;
            M_READ:  state_next = S_RD;
            M_PAINT: state_next = S_PSET;
            M_FILL:  state_next = S_FSEED;
            M_SOLID: begin
              px_next = '0;
              py_next = '0;
              lo_x_next = '0;
              hi_x_next = CW'(wu - 7'd1);
              hi_y_next = CW'(hu - 7'd1);
              state_next = (wu == 7'd0 || hu == 7'd0) ? S_DONE : S_SRD;
            end
            M_CLEAR: begin
              clr_addr_next = '0;
              clr_cmd_next = 1'b1;
              state_next = S_INIT;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_WR: begin
        res_ib_next = inside_grid(x_r, y_r, wu, hu);
        t_we = res_ib_next;
        state_next = S_DONE;
      end
      S_RD: state_next = S_RD2;
      S_RD2: begin
        res_ib_next = inside_grid(x_r, y_r, wu, hu);
        res_id_next = res_ib_next ? t_rd[15:0] : 16'd0;
        res_sol_next = res_ib_next & t_rd[16];
        state_next = S_DONE;
      end
      S_PSET: begin
        res_ib_next = inside_grid(x_r, y_r, wu, hu);
        lo_x_next = lxs[CW-1:0];
        hi_x_next = hxs[CW-1:0];
        hi_y_next = hys[CW-1:0];
        px_next = lxs[CW-1:0];
        py_next = lys[CW-1:0];
        state_next = (lxs > hxs || lys > hys) ? S_DONE : S_PAINT;
      end
      S_PAINT: begin
        t_addr = {py, px};
        t_we = 1'b1;
        if (px == hi_x) begin
          px_next = lo_x;
          py_next = py + 1'b1;
          if (py == hi_y) state_next = S_DONE;
        end else begin
          px_next = px + 1'b1;
        end
      end
      S_SRD: begin
        t_addr = {py, px};
        state_next = S_SWR;
      end
      S_SWR: begin
        t_addr = {py, px};
        t_we = (t_rd[15:0] == id_r);
        t_wd = {sol_r, t_rd[15:0]};
        state_next = S_SRD;
        if (px == hi_x) begin
          px_next = lo_x;
          py_next = py + 1'b1;
          if (py == hi_y) state_next = S_DONE;
        end else begin
          px_next = px + 1'b1;
        end
      end
      S_FSEED: begin
        res_ib_next = inside_grid(x_r, y_r, wu, hu);
        state_next = res_ib_next ? S_FOLD : S_DONE;
      end
      S_FOLD: begin
        old_id_next = t_rd[15:0];
        if (t_rd[15:0] == id_r) begin
          state_next = S_DONE;
        end else begin
          s_addr = '0;
          s_we = 1'b1;
          s_wd = {1'b0, y_r[CW-1:0], 1'b0, x_r[CW-1:0]};
          scount_next = SC_W'(1);
          state_next = S_FPOP;
        end
      end
      S_FPOP: begin
        if (scount == '0) begin
          state_next = S_DONE;
        end else begin
          s_addr = SP_W'(scount - 1'b1);
          scount_next = scount - 1'b1;
          state_next = S_FSRD;
        end
      end
      S_FSRD: begin
        cx_next = s_rd[CW-1:0];
        cy_next = s_rd[7+CW-1:7];
        t_addr = {s_rd[7+CW-1:7], s_rd[CW-1:0]};
        state_next = S_FCHK;
      end
      S_FCHK: begin
        t_addr = {cy, cx};
        k_next = '0;
        if (t_rd[15:0] == old_id) begin
          t_we = 1'b1;
          state_next = S_FPUSH;
        end else begin
          state_next = S_FPOP;
        end
      end
      S_FPUSH: begin
        k_next = k + 1'b1;
        if (k == 2'd3) state_next = S_FPOP;
        if (n_in) begin
          if (scount[SC_W-1]) begin
            res_ovf_next = 1'b1;
            scount_next = '0;
            state_next = S_DONE;
          end else begin
            s_we = 1'b1;
            scount_next = scount + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_ch.valid || out_ch.ready) begin
          load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state != S_IDLE)
    else $error("accepted item left sequencer idle");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    !scount[SC_W-1] || scount[SP_W-1:0] == '0)
    else $error("fill stack count beyond depth");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state == S_DONE))
    else $error("result loaded outside done state");
  a_idle_stack_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> scount == '0)
    else $error("fill stack not empty at idle");
endmodule
